### rtl/qrs_pkg.sv
// Package for the quadratic root solver: default sizes, root count codes
// and width helpers shared by the front, the queue and the back end.
// No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;

	localparam int COEF_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int ROOT_WIDTH = 40;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE = 2'd1;
	localparam logic [1:0] CNT_TWO = 2'd2;
	localparam logic [1:0] CNT_INF = 2'd3;

	// Signed discriminant b*b - 4*a*c.
	function automatic int f_disc_w(input int cw);
		return 2 * cw + 2;
	endfunction

	// Square root of the positive discriminant scaled by 2^(2*frac).
	function automatic int f_sqrt_w(input int cw, input int fr);
		return (f_disc_w(cw) - 1 + 2 * fr + 1) / 2;
	endfunction

	// Signed numerator (-b scaled, plus or minus the root) with margin.
	function automatic int f_num_w(input int cw, input int fr);
		int a;
		int b;
		a = cw + fr + 1;
		b = f_sqrt_w(cw, fr) + 1;
		return ((a > b) ? a : b) + 1;
	endfunction

	// Divisor magnitude: |2a| or |b|.
	function automatic int f_den_w(input int cw);
		return cw + 1;
	endfunction

	// Queue entry: count, clear flag, numerator, divisor sign and magnitude, radicand.
	function automatic int f_queue_w(input int cw, input int fr);
		return 2 + 1 + f_num_w(cw, fr) + 1 + f_den_w(cw) + 2 * f_sqrt_w(cw, fr);
	endfunction

endpackage

### rtl/qrs_in_if.sv
// Equation channel: valid/ready handshake carrying coefficients a, b, c.
// No dependencies.
`timescale 1ns / 1ps
interface qrs_in_if #(
	parameter int COEF_WIDTH = 16
) ();
	logic valid;
	logic ready;
	logic signed [COEF_WIDTH-1:0] coef_a;
	logic signed [COEF_WIDTH-1:0] coef_b;
	logic signed [COEF_WIDTH-1:0] coef_c;

	modport source(output valid, output coef_a, output coef_b, output coef_c, input ready);
	modport sink(input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

### rtl/qrs_out_if.sv
// Result channel: valid/ready handshake carrying the root count and roots.
// No dependencies.
`timescale 1ns / 1ps
interface qrs_out_if ();
	logic valid;
	logic ready;
	logic [1:0] root_count;
	logic signed [39:0] first_root;
	logic signed [39:0] second_root;

	modport source(output valid, output root_count, output first_root,
		output second_root, input ready);
	modport sink(input valid, input root_count, input first_root,
		input second_root, output ready);
endinterface

### rtl/qrs_front.sv
// Front end: accepts equations, forms b*b and a*c, then the discriminant,
// and classifies each item into a queue entry. Depends on qrs_pkg, qrs_in_if.
`timescale 1ns / 1ps
module qrs_front #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
	parameter int QW = qrs_pkg::f_queue_w(COEF_WIDTH, FRAC_BITS)
) (
	input logic clk,
	input logic arst_n,
	qrs_in_if.sink eqn,
	input logic q_full,
	output logic q_push,
	output logic [QW-1:0] q_data
);
	import qrs_pkg::*;

	localparam int CW = COEF_WIDTH;
	localparam int DW = f_disc_w(CW);
	localparam int SW = f_sqrt_w(CW, FRAC_BITS);
	localparam int NW = f_num_w(CW, FRAC_BITS);
	localparam int DMW = f_den_w(CW);

	logic v_s1;
	logic signed [CW-1:0] a_s1, b_s1, c_s1;
	logic signed [2*CW-1:0] bb_s1, ac_s1;
	logic adv;

	logic signed [DW-1:0] disc;
	logic [DW-2:0] disc_mag;
	logic signed [DMW-1:0] a_ext, b_ext;
	logic [DMW-1:0] a_mag, b_mag;
	logic [1:0] cnt;
	logic clr2;
	logic signed [NW-1:0] num;
	logic dneg;
	logic [DMW-1:0] dmag;
	logic [2*SW-1:0] rad;

	assign adv = !v_s1 || !q_full;
	assign eqn.ready = adv;
	assign q_push = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= eqn.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && eqn.valid) begin
			a_s1 <= eqn.coef_a;
			b_s1 <= eqn.coef_b;
			c_s1 <= eqn.coef_c;
			bb_s1 <= eqn.coef_b * eqn.coef_b;
			ac_s1 <= eqn.coef_a * eqn.coef_c;
		end
	end

	assign disc = DW'(bb_s1) - (DW'(ac_s1) <<< 2);
	assign disc_mag = disc[DW-2:0];
	assign a_ext = DMW'(a_s1);
	assign b_ext = DMW'(b_s1);
	assign a_mag = a_s1[CW-1] ? unsigned'(-a_ext) : unsigned'(a_ext);
	assign b_mag = b_s1[CW-1] ? unsigned'(-b_ext) : unsigned'(b_ext);

	always_comb begin
		cnt = CNT_NONE;
		clr2 = 1'b1;
		num = '0;
		dneg = 1'b0;
		dmag = DMW'(1);
		rad = '0;
		if (a_s1 == '0) begin
			if (b_s1 != '0) begin
				cnt = CNT_ONE;
				num = -(NW'(c_s1) <<< FRAC_BITS);
				dneg = b_s1[CW-1];
				dmag = b_mag;
			end else begin
				cnt = (c_s1 == '0) ? CNT_INF : CNT_NONE;
			end
		end else if (!disc[DW-1]) begin
			// A zero discriminant runs through the same path with a zero root,
			// so both roots come out equal.
			cnt = (disc == '0) ? CNT_ONE : CNT_TWO;
			clr2 = 1'b0;
			num = -(NW'(b_s1) <<< FRAC_BITS);
			dneg = a_s1[CW-1];
			dmag = a_mag << 1;
			rad = (2*SW)'(disc_mag) << (2 * FRAC_BITS);
		end
	end

	assign q_data = {cnt, clr2, num, dneg, dmag, rad};

endmodule

### rtl/qrs_queue.sv
// Short register queue between the front end and the back end.
// Depends on qrs_pkg for its depth.
`timescale 1ns / 1ps
module qrs_queue #(
	parameter int QW = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [QW-1:0] wdata,
	output logic full,
	input logic pop,
	output logic nonempty,
	output logic [QW-1:0] rdata
);
	import qrs_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);

	logic [QW-1:0] mem_q [0:QUEUE_DEPTH-1];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign full = (cnt_q == (AW+1)'(QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule

### rtl/qrs_back.sv
// Back end: pipelined digit-by-digit square root, then two pipelined
// restoring dividers for both roots, then the output register.
// Depends on qrs_pkg and qrs_out_if.
`timescale 1ns / 1ps
module qrs_back #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF,
	parameter int QW = qrs_pkg::f_queue_w(COEF_WIDTH, FRAC_BITS)
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input logic [QW-1:0] q_data,
	qrs_out_if.source sol
);
	import qrs_pkg::*;

	localparam int CW = COEF_WIDTH;
	localparam int SW = f_sqrt_w(CW, FRAC_BITS);
	localparam int NW = f_num_w(CW, FRAC_BITS);
	localparam int DMW = f_den_w(CW);

	logic adv;

	// Square root stages; index 0 is the queue head.
	logic sr_v [0:SW];
	logic [SW:0] sr_rem [0:SW];
	logic [SW-1:0] sr_root [0:SW];
	logic [2*SW-1:0] sr_rad [0:SW];
	logic signed [NW-1:0] sr_num [0:SW];
	logic sr_dneg [0:SW];
	logic [DMW-1:0] sr_den [0:SW];
	logic [1:0] sr_cnt [0:SW];
	logic sr_clr2 [0:SW];

	// Divider stages; index 0 holds the two numerator magnitudes.
	logic dv_v [0:NW];
	logic [DMW-1:0] dv_den [0:NW];
	logic [1:0] dv_cnt [0:NW];
	logic dv_clr2 [0:NW];
	logic [NW-1:0] dv_dq [0:NW][0:1];
	logic [DMW-1:0] dv_rem [0:NW][0:1];
	logic dv_neg [0:NW][0:1];

	logic out_v_q;
	logic [1:0] cnt_q;
	logic signed [ROOT_WIDTH-1:0] root1_q, root2_q;

	logic signed [NW-1:0] p_s, p_n1, p_n2;
	logic signed [NW-1:0] res1, res2;

	assign adv = !out_v_q || sol.ready;
	assign q_pop = q_valid && adv;

	assign sr_v[0] = q_valid;
	assign sr_rem[0] = '0;
	assign sr_root[0] = '0;
	assign {sr_cnt[0], sr_clr2[0], sr_num[0], sr_dneg[0], sr_den[0], sr_rad[0]} = q_data;

	for (genvar gk = 1; gk <= SW; gk++) begin : g_sqrt
		logic [SW+2:0] t_rem, t_trial, t_diff;
		logic t_ge;

		assign t_rem = {sr_rem[gk-1], sr_rad[gk-1][2*SW-1 -: 2]};
		assign t_trial = {1'b0, sr_root[gk-1], 2'b01};
		assign t_ge = (t_rem >= t_trial);
		assign t_diff = t_rem - t_trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[gk] <= 1'b0;
			end else if (adv) begin
				sr_v[gk] <= sr_v[gk-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sr_rem[gk] <= t_ge ? t_diff[SW:0] : t_rem[SW:0];
				sr_root[gk] <= {sr_root[gk-1][SW-2:0], t_ge};
				sr_rad[gk] <= {sr_rad[gk-1][2*SW-3:0], 2'b00};
				sr_num[gk] <= sr_num[gk-1];
				sr_dneg[gk] <= sr_dneg[gk-1];
				sr_den[gk] <= sr_den[gk-1];
				sr_cnt[gk] <= sr_cnt[gk-1];
				sr_clr2[gk] <= sr_clr2[gk-1];
			end
		end
	end

	assign p_s = signed'(NW'(sr_root[SW]));
	assign p_n1 = sr_num[SW] + p_s;
	assign p_n2 = sr_num[SW] - p_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= sr_v[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_den[0] <= sr_den[SW];
			dv_cnt[0] <= sr_cnt[SW];
			dv_clr2[0] <= sr_clr2[SW];
			dv_dq[0][0] <= p_n1[NW-1] ? unsigned'(-p_n1) : unsigned'(p_n1);
			dv_dq[0][1] <= p_n2[NW-1] ? unsigned'(-p_n2) : unsigned'(p_n2);
			dv_rem[0][0] <= '0;
			dv_rem[0][1] <= '0;
			dv_neg[0][0] <= p_n1[NW-1] ^ sr_dneg[SW];
			dv_neg[0][1] <= p_n2[NW-1] ^ sr_dneg[SW];
		end
	end

	for (genvar gk = 1; gk <= NW; gk++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[gk] <= 1'b0;
			end else if (adv) begin
				dv_v[gk] <= dv_v[gk-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_den[gk] <= dv_den[gk-1];
				dv_cnt[gk] <= dv_cnt[gk-1];
				dv_clr2[gk] <= dv_clr2[gk-1];
			end
		end

		for (genvar gj = 0; gj < 2; gj++) begin : g_lane
			logic [DMW:0] t_tr, t_sub;
			logic t_ge;

			assign t_tr = {dv_rem[gk-1][gj], dv_dq[gk-1][gj][NW-1]};
			assign t_ge = (t_tr >= {1'b0, dv_den[gk-1]});
			assign t_sub = t_tr - {1'b0, dv_den[gk-1]};

			// Dividend bits shift out at the top while quotient bits enter below.
			always_ff @(posedge clk) begin
				if (adv) begin
					dv_rem[gk][gj] <= t_ge ? t_sub[DMW-1:0] : t_tr[DMW-1:0];
					dv_dq[gk][gj] <= {dv_dq[gk-1][gj][NW-2:0], t_ge};
					dv_neg[gk][gj] <= dv_neg[gk-1][gj];
				end
			end
		end
	end

	assign res1 = dv_neg[NW][0] ? -signed'(dv_dq[NW][0]) : signed'(dv_dq[NW][0]);
	assign res2 = dv_neg[NW][1] ? -signed'(dv_dq[NW][1]) : signed'(dv_dq[NW][1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cnt_q <= dv_cnt[NW];
			root1_q <= ROOT_WIDTH'(res1);
			root2_q <= dv_clr2[NW] ? '0 : ROOT_WIDTH'(res2);
		end
	end

	assign sol.valid = out_v_q;
	assign sol.root_count = cnt_q;
	assign sol.first_root = root1_q;
	assign sol.second_root = root2_q;

endmodule

### rtl/quadratic_root_solver_top.sv
// Quadratic root solver. An item passes from acceptance through the front
// register, the queue, the bit-per-stage square root pipeline, the divider
// input register, the bit-per-stage divider pipeline and the output register.
// Throughput is one item per cycle while sol.ready is not held low.
// Reset clears all valid flags and the queue; no clearing pass.
`timescale 1ns / 1ps
module quadratic_root_solver_top #(
	parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	qrs_in_if.sink eqn,
	qrs_out_if.source sol
);
	import qrs_pkg::*;

	localparam int QW = f_queue_w(COEF_WIDTH, FRAC_BITS);

	logic q_full, q_push, q_pop, q_nonempty;
	logic [QW-1:0] q_wdata, q_rdata;

	qrs_front #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.QW(QW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.eqn(eqn),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	qrs_queue #(
		.QW(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.nonempty(q_nonempty),
		.rdata(q_rdata)
	);

	qrs_back #(
		.COEF_WIDTH(COEF_WIDTH),
		.FRAC_BITS(FRAC_BITS),
		.QW(QW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_nonempty),
		.q_pop(q_pop),
		.q_data(q_rdata),
		.sol(sol)
	);

endmodule
